// File: rtl/pdbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdbc_pkg
// Types and constants for the pill drop beam counter: phase codes, status
// codes, request codes and configuration register indexes.
// ----------------------------------------------------------------------------
package pdbc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ADC_W       = 12;
    localparam int TARGET_W    = 8;
    localparam int SEEN_W      = 8;
    localparam int LIMIT_W     = 16;
    localparam int RETRY_LIM_W = 3;
    localparam int RETRY_W     = 4;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WHEEL  = 3'd1,
        PH_COUNT  = 3'd2,
        PH_REWIND = 3'd3,
        PH_OPEN   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_OK    = 2'd1,
        ST_STUCK = 2'd2,
        ST_RETRY = 2'd3
    } status_t;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_BEAM_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WHEEL_TICKS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUIET_TICKS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REWIND_TICKS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_TICKS     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT    = 3'd5;

    localparam logic [ADC_W-1:0]       RST_BEAM_THRESHOLD = 12'd2048;
    localparam logic [LIMIT_W-1:0]     RST_WHEEL_TICKS    = 16'd500;
    localparam logic [LIMIT_W-1:0]     RST_QUIET_TICKS    = 16'd1000;
    localparam logic [LIMIT_W-1:0]     RST_REWIND_TICKS   = 16'd2000;
    localparam logic [LIMIT_W-1:0]     RST_OPEN_TICKS     = 16'd1000;
    localparam logic [RETRY_LIM_W-1:0] RST_RETRY_LIMIT    = 3'd3;

endpackage
`default_nettype wire

// File: rtl/pill_drop_beam_counter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pill_drop_beam_counter_core
// Dispense sequencer: wheel pulse, beam counting window with quiet timeout,
// tray rewind on overcount, tray open on exact count.
// ----------------------------------------------------------------------------
// Output: registered, valid in the cycle after the request is accepted.
// Throughput: 1 request per cycle unless the result stalls; the phase update
//   and the result register load happen in the accept cycle, in_ready is
//   high while the result register is empty or being drained by out_ready.
// Reset: phase idle, counters cleared, config registers at their defaults,
//   no result pending. Ready right after reset; no clearing pass.
module pill_drop_beam_counter_core #(
    parameter int TICK_WIDTH  = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_wen,
    input  wire logic [pdbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [pdbc_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               req_type,
    input  wire logic [pdbc_pkg::TARGET_W-1:0]      pill_target,
    input  wire logic [pdbc_pkg::ADC_W-1:0]         adc_sample,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    wheel_drive,
    output logic                                    rewind_drive,
    output logic                                    open_drive,
    output logic                                    busy_res,
    output logic                                    finished,
    output logic [1:0]                              status,
    output logic [pdbc_pkg::SEEN_W-1:0]             pills_seen
);
    import pdbc_pkg::*;

    localparam int CMP_W = (TICK_WIDTH > LIMIT_W) ? TICK_WIDTH : LIMIT_W;
    localparam logic [TICK_WIDTH-1:0]  TICK_MAX  = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // configuration
    logic [ADC_W-1:0]       thr_reg;
    logic [LIMIT_W-1:0]     wheel_lim_reg;
    logic [LIMIT_W-1:0]     quiet_lim_reg;
    logic [LIMIT_W-1:0]     rewind_lim_reg;
    logic [LIMIT_W-1:0]     open_lim_reg;
    logic [RETRY_LIM_W-1:0] retry_lim_reg;

    // sequencer state
    phase_t                 phase_reg,  phase_next;
    logic [TICK_WIDTH-1:0]  ticks_reg,  ticks_next;
    logic [COUNT_WIDTH-1:0] count_reg,  count_next;
    logic [COUNT_WIDTH-1:0] target_reg, target_next;
    logic                   blocked_reg, blocked_next;
    logic [RETRY_W-1:0]     retry_reg,  retry_next;

    // result register
    logic                   out_valid_reg;
    logic                   wheel_reg,  wheel_next;
    logic                   rewind_reg, rewind_next;
    logic                   open_reg,   open_next;
    logic                   busy_reg,   busy_next;
    logic                   fin_reg,    fin_next;
    status_t                st_reg,     st_next;
    logic [SEEN_W-1:0]      seen_reg,   seen_next;

    logic                   in_acc;
    logic [TICK_WIDTH-1:0]  ticks_inc;
    logic                   beam_blk;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_acc    = in_valid && in_ready;
    assign ticks_inc = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign beam_blk  = adc_sample < thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= RST_BEAM_THRESHOLD;
            wheel_lim_reg  <= RST_WHEEL_TICKS;
            quiet_lim_reg  <= RST_QUIET_TICKS;
            rewind_lim_reg <= RST_REWIND_TICKS;
            open_lim_reg   <= RST_OPEN_TICKS;
            retry_lim_reg  <= RST_RETRY_LIMIT;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_BEAM_THRESHOLD: thr_reg        <= cfg_data[ADC_W-1:0];
                CFG_WHEEL_TICKS:    wheel_lim_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_QUIET_TICKS:    quiet_lim_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_REWIND_TICKS:   rewind_lim_reg <= cfg_data[LIMIT_W-1:0];
                CFG_OPEN_TICKS:     open_lim_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_RETRY_LIMIT:    retry_lim_reg  <= cfg_data[RETRY_LIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        ticks_next   = ticks_reg;
        count_next   = count_reg;
        target_next  = target_reg;
        blocked_next = blocked_reg;
        retry_next   = retry_reg;
        fin_next     = 1'b0;
        st_next      = ST_NONE;
        if (in_acc)
        begin
            if (req_type == REQ_START)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    target_next  = COUNT_WIDTH'(pill_target);
                    count_next   = '0;
                    retry_next   = '0;
                    blocked_next = 1'b0;
                    ticks_next   = '0;
                    phase_next   = (COUNT_WIDTH'(pill_target) == '0) ? PH_OPEN : PH_WHEEL;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE: ;
                    PH_WHEEL:
                    begin
                        ticks_next = ticks_inc;
                        if (CMP_W'(ticks_inc) >= CMP_W'(wheel_lim_reg))
                        begin
                            phase_next = PH_COUNT;
                            ticks_next = '0;
                        end
                    end
                    PH_COUNT:
                    begin
                        if (beam_blk != blocked_reg)
                        begin
                            blocked_next = beam_blk;
                            if (beam_blk && count_reg != COUNT_MAX)
                                count_next = count_reg + 1'b1;
                            ticks_next = '0;
                        end
                        else
                        begin
                            ticks_next = ticks_inc;
                            if (CMP_W'(ticks_inc) >= CMP_W'(quiet_lim_reg))
                            begin
                                ticks_next = '0;
                                if (blocked_reg)
                                begin
                                    phase_next = PH_IDLE;
                                    fin_next   = 1'b1;
                                    st_next    = ST_STUCK;
                                end
                                else if (count_reg > target_reg)
                                begin
                                    count_next = '0;
                                    retry_next = retry_reg + 1'b1;
                                    phase_next = PH_REWIND;
                                end
                                else if (count_reg < target_reg)
                                    phase_next = PH_WHEEL;
                                else
                                    phase_next = PH_OPEN;
                            end
                        end
                    end
                    PH_REWIND:
                    begin
                        ticks_next = ticks_inc;
                        if (CMP_W'(ticks_inc) >= CMP_W'(rewind_lim_reg))
                        begin
                            ticks_next = '0;
                            if (retry_reg > RETRY_W'(retry_lim_reg))
                            begin
                                phase_next = PH_IDLE;
                                fin_next   = 1'b1;
                                st_next    = ST_RETRY;
                            end
                            else
                                phase_next = PH_WHEEL;
                        end
                    end
                    PH_OPEN:
                    begin
                        ticks_next = ticks_inc;
                        if (CMP_W'(ticks_inc) >= CMP_W'(open_lim_reg))
                        begin
                            ticks_next = '0;
                            phase_next = PH_IDLE;
                            fin_next   = 1'b1;
                            st_next    = ST_OK;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // result fields from the updated state
    always_comb
    begin
        wheel_next  = 1'b0;
        rewind_next = 1'b0;
        open_next   = 1'b0;
        busy_next   = 1'b1;
        case (phase_next)
            PH_IDLE:   busy_next   = 1'b0;
            PH_WHEEL:  wheel_next  = 1'b1;
            PH_COUNT:  ;
            PH_REWIND: rewind_next = 1'b1;
            PH_OPEN:   open_next   = 1'b1;
            default:   busy_next   = 1'b1;
        endcase
        seen_next = SEEN_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            ticks_reg     <= '0;
            count_reg     <= '0;
            target_reg    <= '0;
            blocked_reg   <= 1'b0;
            retry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            ticks_reg   <= ticks_next;
            count_reg   <= count_next;
            target_reg  <= target_next;
            blocked_reg <= blocked_next;
            retry_reg   <= retry_next;
            if (in_acc)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            wheel_reg  <= wheel_next;
            rewind_reg <= rewind_next;
            open_reg   <= open_next;
            busy_reg   <= busy_next;
            fin_reg    <= fin_next;
            st_reg     <= st_next;
            seen_reg   <= seen_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign wheel_drive  = wheel_reg;
    assign rewind_drive = rewind_reg;
    assign open_drive   = open_reg;
    assign busy_res     = busy_reg;
    assign finished     = fin_reg;
    assign status       = st_reg;
    assign pills_seen   = seen_reg;

    // a wheel, count or rewind phase only exists with a nonzero target
    a_target_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WHEEL || phase_reg == PH_COUNT || phase_reg == PH_REWIND)
        |-> target_reg != '0)
        else $error("drive phase with zero target");

    a_fin_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fin_reg) |-> (st_reg != ST_NONE && !busy_reg))
        else $error("finish without status or while busy");

    a_status_only_on_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !fin_reg) |-> st_reg == ST_NONE)
        else $error("status reported without finish");

    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (wheel_reg || rewind_reg || open_reg)) |-> busy_reg)
        else $error("drive active while not busy");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && phase_reg == PH_IDLE && req_type == REQ_TICK)
        |=> (phase_reg == PH_IDLE && !fin_reg))
        else $error("idle tick changed phase");

endmodule
`default_nettype wire
